[rtl/core/bphd_pkg.sv]
// Package for the button press and hold detector.
// Holds the shared constants, event codes, state type and the controller/datapath structs.
// No dependencies.
package bphd_pkg;

    // Number of buttons that the block tracks.
    localparam int BUTTON_COUNT = 5;

    // Field widths.
    localparam int IDX_W  = 3;
    localparam int TICK_W = 16;
    localparam int KIND_W = 2;

    // Hold time after reset, in ticks.
    localparam logic [TICK_W-1:0] HOLD_TICKS_RESET = 16'd1000;

    // Input operation codes.
    localparam logic OP_PIN  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Pin level that means pressed (active low).
    localparam logic LEVEL_PRESSED = 1'b0;

    // Event codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_DOWN = 2'd0,
        KIND_UP   = 2'd1,
        KIND_HOLD = 2'd2
    } event_kind_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIN,
        ST_SCAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic pin_apply;
        logic scan_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_op;
        logic pin_event;
        logic scan_fire;
        logic scan_at_end;
        logic out_busy;
    } status_t;

endpackage

[rtl/core/bphd_if.sv]
// Channel interfaces for the button press and hold detector.
// Input items and event results, each with valid/ready handshake; uses bphd_pkg.
interface bphd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [bphd_pkg::IDX_W-1:0]  button_index;
    logic                        pin_level;

    modport source (output valid, output op, output button_index, output pin_level,
                    input ready);
    modport sink (input valid, input op, input button_index, input pin_level,
                  output ready);
endinterface

interface bphd_out_if;
    logic                        valid;
    logic                        ready;
    logic [bphd_pkg::KIND_W-1:0] event_kind;
    logic [bphd_pkg::IDX_W-1:0]  button_id;
    logic                        last;

    modport source (output valid, output event_kind, output button_id, output last,
                    input ready);
    modport sink (input valid, input event_kind, input button_id, input last,
                  output ready);
endinterface

[rtl/core/bphd_ctrl.sv]
// Controller state machine of the button press and hold detector.
// Sequences item acceptance, pin handling and the per-button tick scan; uses bphd_pkg.
module bphd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bphd_pkg::status_t status,
    output bphd_pkg::cmd_t    cmd
);

    bphd_pkg::state_t state_reg;
    bphd_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bphd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            bphd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = (status.in_op == bphd_pkg::OP_TICK) ? bphd_pkg::ST_SCAN
                                                                      : bphd_pkg::ST_PIN;
                end
            end
            bphd_pkg::ST_PIN:
            begin
                // Wait only when an event must go out and the output is still occupied.
                if (!(status.pin_event && status.out_busy))
                begin
                    cmd.pin_apply = 1'b1;
                    state_next = bphd_pkg::ST_IDLE;
                end
            end
            bphd_pkg::ST_SCAN:
            begin
                if (!(status.scan_fire && status.out_busy))
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_at_end)
                    begin
                        state_next = bphd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bphd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/bphd_dp.sv]
// Datapath of the button press and hold detector.
// Per-button state, hold countdowns, scan counter, hold time register and output register;
// uses bphd_pkg.
module bphd_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bphd_pkg::cmd_t                cmd,
    output bphd_pkg::status_t             status,
    input  logic                          hold_ticks_we,
    input  logic [bphd_pkg::TICK_W-1:0]   hold_ticks_wdata,
    input  logic                          in_op,
    input  logic [bphd_pkg::IDX_W-1:0]    in_button_index,
    input  logic                          in_pin_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bphd_pkg::KIND_W-1:0]   out_event_kind,
    output logic [bphd_pkg::IDX_W-1:0]    out_button_id,
    output logic                          out_last
);

    localparam int N = bphd_pkg::BUTTON_COUNT;

    logic [bphd_pkg::TICK_W-1:0] hold_ticks_reg;

    logic [N-1:0] down_reg;
    logic [N-1:0] down_next;
    logic [N-1:0] held_reg;
    logic [N-1:0] held_next;
    logic [N-1:0] run_reg;
    logic [N-1:0] run_next;
    logic [bphd_pkg::TICK_W-1:0] ticks_reg [N];
    logic [bphd_pkg::TICK_W-1:0] ticks_next [N];

    logic [bphd_pkg::IDX_W-1:0] idx_reg;
    logic                       level_reg;
    logic [bphd_pkg::IDX_W-1:0] scan_reg;
    logic [bphd_pkg::IDX_W-1:0] scan_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [bphd_pkg::KIND_W-1:0] kind_reg;
    logic [bphd_pkg::KIND_W-1:0] kind_next;
    logic [bphd_pkg::IDX_W-1:0]  button_reg;
    logic [bphd_pkg::IDX_W-1:0]  button_next;
    logic                        last_reg;
    logic                        last_next;

    logic         idx_ok;
    logic         pressed;
    logic         cur_down;
    logic         cur_held;
    logic         pin_event;
    logic [N-1:0] fire;
    logic         later_fire;
    logic         scan_fire;
    logic         emit;

    // Pin report decode against the stored button state.
    always_comb
    begin
        idx_ok    = (idx_reg < bphd_pkg::IDX_W'(N));
        pressed   = (level_reg == bphd_pkg::LEVEL_PRESSED);
        cur_down  = idx_ok ? down_reg[idx_reg] : 1'b0;
        cur_held  = idx_ok ? held_reg[idx_reg] : 1'b0;
        pin_event = idx_ok && (pressed != cur_down);
    end

    // Countdowns that finish on this tick, and whether any lies beyond the scanned button.
    always_comb
    begin
        later_fire = 1'b0;
        for (int b = 0; b < N; b++)
        begin
            fire[b] = run_reg[b] && (ticks_reg[b] <= bphd_pkg::TICK_W'(1));
            if (bphd_pkg::IDX_W'(b) > scan_reg && fire[b])
            begin
                later_fire = 1'b1;
            end
        end
        scan_fire = fire[scan_reg];
    end

    // Next state of the button registers, scan counter and output register.
    always_comb
    begin
        down_next      = down_reg;
        held_next      = held_reg;
        run_next       = run_reg;
        ticks_next     = ticks_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        button_next    = button_reg;
        last_next      = last_reg;
        emit           = 1'b0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load_item)
        begin
            scan_next = '0;
        end

        // Press or release of one button.
        if (cmd.pin_apply && pin_event)
        begin
            emit        = 1'b1;
            button_next = idx_reg;
            last_next   = 1'b1;
            if (pressed)
            begin
                down_next[idx_reg]  = 1'b1;
                held_next[idx_reg]  = 1'b0;
                run_next[idx_reg]   = 1'b1;
                ticks_next[idx_reg] = hold_ticks_reg;
                kind_next           = bphd_pkg::KIND_DOWN;
            end
            else
            begin
                down_next[idx_reg] = 1'b0;
                if (!cur_held)
                begin
                    run_next[idx_reg]   = 1'b0;
                    ticks_next[idx_reg] = '0;
                end
                held_next[idx_reg] = 1'b0;
                kind_next          = bphd_pkg::KIND_UP;
            end
        end

        // One button of the tick scan.
        if (cmd.scan_step)
        begin
            scan_next = scan_reg + bphd_pkg::IDX_W'(1);
            if (run_reg[scan_reg])
            begin
                if (scan_fire)
                begin
                    ticks_next[scan_reg] = '0;
                    run_next[scan_reg]   = 1'b0;
                    held_next[scan_reg]  = 1'b1;
                    emit                 = 1'b1;
                    kind_next            = bphd_pkg::KIND_HOLD;
                    button_next          = scan_reg;
                    last_next            = !later_fire;
                end
                else
                begin
                    ticks_next[scan_reg] = ticks_reg[scan_reg] - bphd_pkg::TICK_W'(1);
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= bphd_pkg::HOLD_TICKS_RESET;
            down_reg       <= '0;
            held_reg       <= '0;
            run_reg        <= '0;
            for (int b = 0; b < N; b++)
            begin
                ticks_reg[b] <= '0;
            end
            scan_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (hold_ticks_we)
            begin
                hold_ticks_reg <= hold_ticks_wdata;
            end
            down_reg      <= down_next;
            held_reg      <= held_next;
            run_reg       <= run_next;
            ticks_reg     <= ticks_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            idx_reg   <= in_button_index;
            level_reg <= in_pin_level;
        end
        kind_reg   <= kind_next;
        button_reg <= button_next;
        last_reg   <= last_next;
    end

    // Status and output ports.
    always_comb
    begin
        status.in_op       = in_op;
        status.pin_event   = pin_event;
        status.scan_fire   = scan_fire;
        status.scan_at_end = (scan_reg == bphd_pkg::IDX_W'(N - 1));
        status.out_busy    = out_valid_reg && !out_ready;
        out_valid          = out_valid_reg;
        out_event_kind     = kind_reg;
        out_button_id      = button_reg;
        out_last           = last_reg;
    end

endmodule

[rtl/core/button_press_hold_detector.sv]
// Top level of the button press and hold detector.
// Joins the controller and the datapath; uses bphd_pkg, bphd_in_if and bphd_out_if.
//
//  Channel           Direction  Carries
//  item_ch           in         op, button_index, pin_level
//  event_ch          out        event_kind, button_id, last
//  hold_ticks_we/wd  in         hold time register write
//
// A pin report is accepted in ST_IDLE, then ST_PIN updates the button and loads the event.
// A tick is accepted in ST_IDLE, then ST_SCAN visits one button per cycle unless a stalled output holds it.
// A stalled output register holds the controller only when a new event must be loaded.
// Reset clears all button state and sets the hold time to 1000 ticks.
module button_press_hold_detector (
    input  logic                        clk,
    input  logic                        rst_n,
    bphd_in_if.sink                     item_ch,
    bphd_out_if.source                  event_ch,
    input  logic                        hold_ticks_we,
    input  logic [bphd_pkg::TICK_W-1:0] hold_ticks_wdata
);

    bphd_pkg::cmd_t    cmd;
    bphd_pkg::status_t status;

    // Sequencer.
    bphd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_ch.valid),
        .in_ready (item_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Button state and event output.
    bphd_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .hold_ticks_we    (hold_ticks_we),
        .hold_ticks_wdata (hold_ticks_wdata),
        .in_op            (item_ch.op),
        .in_button_index  (item_ch.button_index),
        .in_pin_level     (item_ch.pin_level),
        .out_valid        (event_ch.valid),
        .out_ready        (event_ch.ready),
        .out_event_kind   (event_ch.event_kind),
        .out_button_id    (event_ch.button_id),
        .out_last         (event_ch.last)
    );

endmodule

[rtl/core/bphd_checker.sv]
// Port-level checker for the button press and hold detector, with its bind statement.
// Uses bphd_pkg; attaches to button_press_hold_detector.
module bphd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bphd_pkg::KIND_W-1:0] out_kind,
    input logic [bphd_pkg::IDX_W-1:0]  out_button,
    input logic                        out_last
);

    // A pending event stays offered until its transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("event dropped while stalled");

    // A stalled event keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_button) && $stable(out_last))
        else $error("event payload changed while stalled");

    // One item at a time: an accepted item makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted back to back");

    // Events name a real button.
    a_button_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_button < bphd_pkg::IDX_W'(bphd_pkg::BUTTON_COUNT))
        else $error("event for a nonexistent button");

    // Down and up events are the only event of their pin report.
    a_pin_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == bphd_pkg::KIND_DOWN || out_kind == bphd_pkg::KIND_UP)
        |-> out_last)
        else $error("pin event not marked last");

endmodule

bind button_press_hold_detector bphd_checker u_bphd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item_ch.valid),
    .in_ready   (item_ch.ready),
    .out_valid  (event_ch.valid),
    .out_ready  (event_ch.ready),
    .out_kind   (event_ch.event_kind),
    .out_button (event_ch.button_id),
    .out_last   (event_ch.last)
);
